[rtl/pgm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pgm_pkg;

	localparam int CHAR_W          = 16;
	localparam int MAX_PATTERN_DEF = 32;

	localparam logic [CHAR_W-1:0] STAR_CODE  = 16'd42;
	localparam logic [CHAR_W-1:0] QMARK_CODE = 16'd63;
	localparam logic [CHAR_W-1:0] SEP_RESET  = 16'd47;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_PATH   = 2'd2;

	localparam logic [1:0] CFG_SEP    = 2'd0;
	localparam logic [1:0] CFG_ICASE  = 2'd1;
	localparam logic [1:0] CFG_PREFIX = 2'd2;

	typedef struct packed {
		logic [CHAR_W-1:0] sep;
		logic              fold_en;
		logic              allow_prefix;
	} cfg_t;

	function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 16'd65 && c <= 16'd90) begin
			r = c + 16'd32;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/pgm_nfa.sv]
`timescale 1ns / 1ps
`default_nettype none

module pgm_nfa #(
	parameter int MAX_PATTERN = pgm_pkg::MAX_PATTERN_DEF,
	parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
	input  wire pgm_pkg::cfg_t                                   cfg,
	input  wire logic [MAX_PATTERN-1:0][pgm_pkg::CHAR_W-1:0]     store,
	input  wire logic [LW-1:0]                                   len,
	input  wire logic [MAX_PATTERN:0]                            act,
	input  wire logic [pgm_pkg::CHAR_W-1:0]                      chr,
	output logic      [MAX_PATTERN:0]                            adv_vec,
	output logic      [MAX_PATTERN:0]                            init_vec
);
	import pgm_pkg::*;

	logic                   c_sep;
	logic [CHAR_W-1:0]      c_fold;
	logic [MAX_PATTERN-1:0] en;
	logic [MAX_PATTERN-1:0] star;
	logic [MAX_PATTERN-1:0] stay;
	logic [MAX_PATTERN-1:0] step;
	logic [MAX_PATTERN:0]   nxt;

	assign c_sep  = (chr == cfg.sep);
	assign c_fold = fold_char(chr);

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_lane
		logic [CHAR_W-1:0] pv;
		logic              k_sep;
		logic              k_any;
		logic              lit_hit;

		assign pv      = store[i];
		assign en[i]   = (len > LW'(i));
		assign k_sep   = (pv == cfg.sep);
		assign star[i] = (pv == STAR_CODE) && !k_sep;
		assign k_any   = (pv == QMARK_CODE) && !k_sep;
		assign lit_hit = (chr == pv) || (cfg.fold_en && (c_fold == fold_char(pv)));

		assign stay[i] = en[i] && act[i] && star[i] && !c_sep;
		assign step[i] = en[i] && act[i] &&
			(k_sep ? c_sep : (!c_sep && (k_any || (!star[i] && lit_hit))));
	end

	assign nxt[0] = stay[0];
	for (genvar i = 1; i < MAX_PATTERN; i++) begin : g_next
		assign nxt[i] = stay[i] | step[i-1];
	end
	assign nxt[MAX_PATTERN] = step[MAX_PATTERN-1];

	// skip stars: ripple active positions forward across runs of '*'
	assign adv_vec[0]  = nxt[0];
	assign init_vec[0] = 1'b1;
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_close
		assign adv_vec[i+1]  = nxt[i+1] | (adv_vec[i] & en[i] & star[i]);
		assign init_vec[i+1] = init_vec[i] & en[i] & star[i];
	end

endmodule

`default_nettype wire

[rtl/path_glob_matcher.sv]
`timescale 1ns / 1ps
`default_nettype none

// Wildcard path matcher.
// Input stream s_axis: one transfer per item. tuser carries the operation
// (clear pattern, append pattern character, path character), tdata the
// 16-bit character; tlast marks the final character of a path. Load a pattern
// with a clear followed by appends, then stream path characters.
// Output stream m_axis: one transfer per path, issued for its tlast
// character; tdata carries matched and pattern_overflow.
// Config channel cfg: index 0 separator, 1 case folding, 2 allow_prefix;
// always ready, write only while the block is idle.
// Throughput: one item per cycle unless a held result stalls it. Result
// path: the input register feeds one NFA update over all pattern positions
// into the result register; the star-skip ripple across MAX_PATTERN
// positions sets the cycle time.
// Reset: pattern length, NFA state and flags clear; registers take their
// defaults (separator '/'). The pattern store is not cleared.
// Stall: a waiting result holds; items that give no result keep flowing,
// and the next result-producing item waits in the input register.
module path_glob_matcher #(
	parameter int MAX_PATTERN = pgm_pkg::MAX_PATTERN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] character
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [7:0]  m_axis_tdata,  // [0] matched, [1] pattern_overflow, zero pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import pgm_pkg::*;

	localparam int LW = $clog2(MAX_PATTERN + 1);

	cfg_t cfg_q;

	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	logic [MAX_PATTERN-1:0][CHAR_W-1:0] store_q;
	logic [LW-1:0]                      len_q;
	logic [MAX_PATTERN:0]               active_q;
	logic                               ovf_q;
	logic                               prefix_q;
	logic                               open_q;

	logic                 out_valid_q;
	logic                 matched_q;
	logic                 out_ovf_q;

	logic                 emits;
	logic                 go;
	logic                 c_is_sep;
	logic                 whole;
	logic [MAX_PATTERN:0] start_vec;
	logic [MAX_PATTERN:0] adv_vec;
	logic [MAX_PATTERN:0] init_vec;
	logic [MAX_PATTERN:0] new_vec;
	logic                 new_prefix;
	logic                 hit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sep          <= SEP_RESET;
			cfg_q.fold_en      <= 1'b0;
			cfg_q.allow_prefix <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SEP:    cfg_q.sep          <= cfg_data;
				CFG_ICASE:  cfg_q.fold_en      <= cfg_data[0];
				CFG_PREFIX: cfg_q.allow_prefix <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	assign emits         = (op_s1 == OP_PATH) && last_s1;
	assign go            = valid_s1 && (!emits || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	pgm_nfa #(
		.MAX_PATTERN (MAX_PATTERN),
		.LW          (LW)
	) u_nfa (
		.cfg      (cfg_q),
		.store    (store_q),
		.len      (len_q),
		.act      (start_vec),
		.chr      (char_s1),
		.adv_vec  (adv_vec),
		.init_vec (init_vec)
	);

	assign c_is_sep   = (char_s1 == cfg_q.sep);
	assign whole      = (len_q != '0) && (store_q[0] == cfg_q.sep);
	assign start_vec  = open_q ? active_q : init_vec;
	assign new_vec    = (c_is_sep && !whole) ? init_vec : adv_vec;
	assign new_prefix = (open_q && prefix_q) || (whole && c_is_sep && start_vec[len_q]);
	assign hit        = (new_vec[len_q] || (whole && cfg_q.allow_prefix && new_prefix)) && !ovf_q;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_store
		always_ff @(posedge clk) begin
			if (go && op_s1 == OP_APPEND && len_q == LW'(i)) begin
				store_q[i] <= char_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			active_q <= '0;
			ovf_q    <= 1'b0;
			prefix_q <= 1'b0;
			open_q   <= 1'b0;
		end else if (go) begin
			case (op_s1)
				OP_CLEAR: begin
					len_q    <= '0;
					active_q <= '0;
					ovf_q    <= 1'b0;
					prefix_q <= 1'b0;
					open_q   <= 1'b0;
				end
				OP_APPEND: begin
					open_q <= 1'b0;
					if (len_q == LW'(MAX_PATTERN)) begin
						ovf_q <= 1'b1;
					end else begin
						len_q <= len_q + LW'(1);
					end
				end
				OP_PATH: begin
					active_q <= new_vec;
					prefix_q <= new_prefix;
					open_q   <= !last_s1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emits) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emits) begin
			matched_q <= hit;
			out_ovf_q <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_ovf_q, matched_q};

`ifndef NO_ASSERTIONS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_PATTERN))
		else $error("pattern length beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LW'(MAX_PATTERN)))
		else $error("overflow flagged with pattern not full");

	a_ovf_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		(go && emits && ovf_q) |=> (out_valid_q && !matched_q && out_ovf_q))
		else $error("match reported on overflowed pattern");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && emits && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while result stage blocked");
`endif

endmodule

`default_nettype wire
